// ----- rtl/tvrg_pkg.sv -----
// ----------------------------------------------------------------------------
// tvrg_pkg: shared types and constants of the triple view ray grid generator
// Configuration register map, axis codes and the structs passed between units.
// ----------------------------------------------------------------------------
`default_nettype none

package tvrg_pkg;

  localparam int STEP_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int COORD_W       = 32;
  localparam int SPACING_W     = 31;
  localparam int VIEW_W        = 2;

  localparam logic [SPACING_W-1:0] SPACING_RST    = SPACING_W'(65536);
  localparam logic [VIEW_W-1:0]    VIEW_LIMIT_RST = VIEW_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_SPACING    = 3'd3,
    CFG_GRID_STEPS = 3'd4,
    CFG_VIEW_LIMIT = 3'd5,
    CFG_REFINE     = 3'd6
  } cfg_idx_t;

  typedef enum logic [VIEW_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic [COORD_W-1:0]   origin_x;
    logic [COORD_W-1:0]   origin_y;
    logic [COORD_W-1:0]   origin_z;
    logic [SPACING_W-1:0] spacing;
    logic [VIEW_W-1:0]    view_limit;
    logic                 refine;
  } cfg_t;

  typedef struct packed {
    logic  done;
    axis_t axis;
  } ray_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/tvrg_cfg.sv -----
// ----------------------------------------------------------------------------
// tvrg_cfg: configuration register file
// Holds origin, spacing, grid step counts, view count and refine mode.
// ----------------------------------------------------------------------------
`default_nettype none

module tvrg_cfg #(
  parameter int STEP_BITS = tvrg_pkg::STEP_BITS_DEF,
  parameter int CFG_W     = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tvrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  output tvrg_pkg::cfg_t                 cfg,
  output logic [3*STEP_BITS-1:0]         grid_steps
);
  import tvrg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x   <= '0;
      cfg.origin_y   <= '0;
      cfg.origin_z   <= '0;
      cfg.spacing    <= SPACING_RST;
      cfg.view_limit <= VIEW_LIMIT_RST;
      cfg.refine     <= 1'b0;
      grid_steps     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:   cfg.origin_x   <= cfg_data[COORD_W-1:0];
        CFG_ORIGIN_Y:   cfg.origin_y   <= cfg_data[COORD_W-1:0];
        CFG_ORIGIN_Z:   cfg.origin_z   <= cfg_data[COORD_W-1:0];
        CFG_SPACING:    cfg.spacing    <= cfg_data[SPACING_W-1:0];
        CFG_GRID_STEPS: grid_steps     <= cfg_data[3*STEP_BITS-1:0];
        CFG_VIEW_LIMIT: cfg.view_limit <= cfg_data[VIEW_W-1:0];
        CFG_REFINE:     cfg.refine     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tvrg_seq.sv -----
// ----------------------------------------------------------------------------
// tvrg_seq: sweep sequencer
// Tracks view, column and row; picks the next ray or a done result per request.
// ----------------------------------------------------------------------------
`default_nettype none

module tvrg_seq #(
  parameter int STEP_BITS = tvrg_pkg::STEP_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   accept,
  input  logic                   restart,
  input  tvrg_pkg::cfg_t         cfg,
  input  logic [3*STEP_BITS-1:0] grid_steps,
  output logic                   item_valid,
  output tvrg_pkg::ray_ctl_t     item_ctl,
  output logic [STEP_BITS-1:0]   item_col,
  output logic [STEP_BITS-1:0]   item_row
);
  import tvrg_pkg::*;

  localparam logic [STEP_BITS-1:0] ONE  = STEP_BITS'(1);
  localparam logic [STEP_BITS-1:0] ZERO = '0;

  logic [VIEW_W-1:0]    view_count, view_count_next;
  logic                 view_active, view_active_next;
  logic [STEP_BITS-1:0] col_index, col_index_next;
  logic [STEP_BITS-1:0] row_index, row_index_next;
  logic [STEP_BITS-1:0] cols_in_view, cols_in_view_next;
  logic [STEP_BITS-1:0] rows_in_view, rows_in_view_next;

  ray_ctl_t             ctl_next;
  logic [STEP_BITS-1:0] col_next, row_next;

  logic [STEP_BITS-1:0] steps_x, steps_y, steps_z;
  logic [STEP_BITS-1:0] cols_v0, rows_v0, cols_v1, rows_v1, cols_v2, rows_v2;
  logic                 ok_v0, ok_v1, ok_v2;

  logic [VIEW_W-1:0]    vc;
  logic                 act, skip, cur_ok;
  logic [STEP_BITS-1:0] sk_col, sk_row, nx_col, nx_row;
  logic [STEP_BITS-1:0] new_cols, new_rows;

  function automatic logic [STEP_BITS-1:0] less_one(input logic [STEP_BITS-1:0] n);
    return (n == ZERO) ? ZERO : n - ONE;
  endfunction

  function automatic logic [2*STEP_BITS-1:0] step_on(
    input logic [STEP_BITS-1:0] c,
    input logic [STEP_BITS-1:0] r,
    input logic [STEP_BITS-1:0] lim
  );
    logic [STEP_BITS-1:0] c1;
    c1 = c + ONE;
    if (c1 >= lim) begin
      return {r + ONE, ZERO};
    end
    return {r, c1};
  endfunction

  assign steps_x = grid_steps[STEP_BITS-1:0];
  assign steps_y = grid_steps[2*STEP_BITS-1:STEP_BITS];
  assign steps_z = grid_steps[3*STEP_BITS-1:2*STEP_BITS];

  assign cols_v0 = less_one(steps_y);
  assign rows_v0 = less_one(steps_z);
  assign cols_v1 = less_one(steps_z);
  assign rows_v1 = less_one(steps_x);
  assign cols_v2 = less_one(steps_x);
  assign rows_v2 = less_one(steps_y);

  always_comb begin
    vc  = restart ? '0 : view_count;
    act = restart ? 1'b0 : view_active;

    ok_v0 = (cols_v0 != ZERO) && (rows_v0 != ZERO) && (vc <= AXIS_X) &&
            (AXIS_X < cfg.view_limit);
    ok_v1 = (cols_v1 != ZERO) && (rows_v1 != ZERO) && (vc <= AXIS_Y) &&
            (AXIS_Y < cfg.view_limit);
    ok_v2 = (cols_v2 != ZERO) && (rows_v2 != ZERO) && (vc <= AXIS_Z) &&
            (AXIS_Z < cfg.view_limit);

    skip = cfg.refine & col_index[0] & row_index[0];
    if (skip) begin
      {sk_row, sk_col} = step_on(col_index, row_index, cols_in_view);
    end else begin
      {sk_row, sk_col} = {row_index, col_index};
    end
    cur_ok = act && (row_index < rows_in_view) && (cols_in_view != ZERO) &&
             (sk_row < rows_in_view);
    {nx_row, nx_col} = step_on(sk_col, sk_row, cols_in_view);

    view_count_next   = view_count;
    view_active_next  = view_active;
    col_index_next    = col_index;
    row_index_next    = row_index;
    cols_in_view_next = cols_in_view;
    rows_in_view_next = rows_in_view;
    new_cols          = cols_v0;
    new_rows          = rows_v0;
    ctl_next.done     = 1'b0;
    ctl_next.axis     = axis_t'(vc - VIEW_W'(1));
    col_next          = sk_col;
    row_next          = sk_row;

    if (cur_ok) begin
      view_count_next  = vc;
      view_active_next = 1'b1;
      col_index_next   = nx_col;
      row_index_next   = nx_row;
    end else if (ok_v0 || ok_v1 || ok_v2) begin
      if (ok_v0) begin
        ctl_next.axis   = AXIS_X;
        view_count_next = VIEW_W'(1);
        new_cols        = cols_v0;
        new_rows        = rows_v0;
      end else if (ok_v1) begin
        ctl_next.axis   = AXIS_Y;
        view_count_next = VIEW_W'(2);
        new_cols        = cols_v1;
        new_rows        = rows_v1;
      end else begin
        ctl_next.axis   = AXIS_Z;
        view_count_next = VIEW_W'(3);
        new_cols        = cols_v2;
        new_rows        = rows_v2;
      end
      view_active_next  = 1'b1;
      cols_in_view_next = new_cols;
      rows_in_view_next = new_rows;
      col_next          = ZERO;
      row_next          = ZERO;
      {row_index_next, col_index_next} = step_on(ZERO, ZERO, new_cols);
    end else begin
      ctl_next.done    = 1'b1;
      ctl_next.axis    = AXIS_X;
      col_next         = ZERO;
      row_next         = ZERO;
      view_active_next = 1'b0;
      view_count_next  = (vc < cfg.view_limit) ? cfg.view_limit : vc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      view_count   <= '0;
      view_active  <= 1'b0;
      col_index    <= '0;
      row_index    <= '0;
      cols_in_view <= '0;
      rows_in_view <= '0;
      item_valid   <= 1'b0;
    end else if (en) begin
      item_valid <= accept;
      if (accept) begin
        view_count   <= view_count_next;
        view_active  <= view_active_next;
        col_index    <= col_index_next;
        row_index    <= row_index_next;
        cols_in_view <= cols_in_view_next;
        rows_in_view <= rows_in_view_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_ctl <= ctl_next;
      item_col <= col_next;
      item_row <= row_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tvrg_point.sv -----
// ----------------------------------------------------------------------------
// tvrg_point: ray start point unit and result register
// Scales column+1 and row+1 by the spacing and offsets the origin on u and v.
// ----------------------------------------------------------------------------
`default_nettype none

module tvrg_point #(
  parameter int STEP_BITS = tvrg_pkg::STEP_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                item_valid,
  input  tvrg_pkg::ray_ctl_t                  item_ctl,
  input  logic [STEP_BITS-1:0]                item_col,
  input  logic [STEP_BITS-1:0]                item_row,
  input  tvrg_pkg::cfg_t                      cfg,
  output logic                                res_valid,
  output logic                                done_res,
  output logic signed [tvrg_pkg::COORD_W-1:0] point_x,
  output logic signed [tvrg_pkg::COORD_W-1:0] point_y,
  output logic signed [tvrg_pkg::COORD_W-1:0] point_z,
  output logic [tvrg_pkg::VIEW_W-1:0]         dir_axis
);
  import tvrg_pkg::*;

  localparam logic [COORD_W-1:0] ONE_C = COORD_W'(1);

  logic [COORD_W-1:0] col_p1, row_p1, scale, du, dv;
  logic [COORD_W-1:0] off_x, off_y, off_z;

  always_comb begin
    col_p1 = COORD_W'(item_col) + ONE_C;
    row_p1 = COORD_W'(item_row) + ONE_C;
    scale  = {1'b0, cfg.spacing};
    du     = col_p1 * scale;
    dv     = row_p1 * scale;
    off_x  = '0;
    off_y  = '0;
    off_z  = '0;
    case (item_ctl.axis)
      AXIS_X: begin
        off_y = du;
        off_z = dv;
      end
      AXIS_Y: begin
        off_z = du;
        off_x = dv;
      end
      AXIS_Z: begin
        off_x = du;
        off_y = dv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && item_valid) begin
      done_res <= item_ctl.done;
      if (item_ctl.done) begin
        point_x  <= '0;
        point_y  <= '0;
        point_z  <= '0;
        dir_axis <= '0;
      end else begin
        point_x  <= cfg.origin_x + off_x;
        point_y  <= cfg.origin_y + off_y;
        point_z  <= cfg.origin_z + off_z;
        dir_axis <= item_ctl.axis;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/triple_view_ray_grid_generator.sv -----
// ----------------------------------------------------------------------------
// triple_view_ray_grid_generator: top level
// Sweeps a rectangular ray grid over up to three axis views, one ray per request.
// ----------------------------------------------------------------------------
// Every request transaction yields exactly one result transaction: the next
// ray start point with its axis, or a done result with zero point and axis
// once the views are exhausted. A request with restart set begins again at the
// first view. Requests are taken one per cycle unless a result waits on
// res_ready; each result passes the sequencer register, the two spacing
// multipliers and the result register in turn. Write the configuration
// registers only while no transaction is in flight; step counts are latched
// when a view is entered, origin, spacing and refine are used as they stand.
// ----------------------------------------------------------------------------
`default_nettype none

module triple_view_ray_grid_generator #(
  parameter int STEP_BITS = tvrg_pkg::STEP_BITS_DEF,
  parameter int CFG_W     = (3 * STEP_BITS > tvrg_pkg::COORD_W) ?
                            3 * STEP_BITS : tvrg_pkg::COORD_W
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tvrg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]                    cfg_data,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                restart,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic                                done_res,
  output logic signed [tvrg_pkg::COORD_W-1:0] point_x,
  output logic signed [tvrg_pkg::COORD_W-1:0] point_y,
  output logic signed [tvrg_pkg::COORD_W-1:0] point_z,
  output logic [tvrg_pkg::VIEW_W-1:0]         dir_axis
);
  import tvrg_pkg::*;

  cfg_t                   cfg;
  logic [3*STEP_BITS-1:0] grid_steps;
  logic                   en, accept;
  logic                   item_valid;
  ray_ctl_t               item_ctl;
  logic [STEP_BITS-1:0]   item_col, item_row;

  assign en        = !res_valid || res_ready;
  assign req_ready = en;
  assign accept    = req_valid && en;

  tvrg_cfg #(
    .STEP_BITS (STEP_BITS),
    .CFG_W     (CFG_W)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .grid_steps (grid_steps)
  );

  tvrg_seq #(
    .STEP_BITS (STEP_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .accept     (accept),
    .restart    (restart),
    .cfg        (cfg),
    .grid_steps (grid_steps),
    .item_valid (item_valid),
    .item_ctl   (item_ctl),
    .item_col   (item_col),
    .item_row   (item_row)
  );

  tvrg_point #(
    .STEP_BITS (STEP_BITS)
  ) u_point (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (item_valid),
    .item_ctl   (item_ctl),
    .item_col   (item_col),
    .item_row   (item_row),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .done_res   (done_res),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .dir_axis   (dir_axis)
  );

endmodule

`default_nettype wire
